FILE: sv/bihc_pkg.sv
// ----------------------------------------------------------------------------
// bihc_pkg: shared types, constants and CRC helpers
// Register map, result codes and the byte-wise reflected CRC-32 step used by
// the boot image header checker.
// ----------------------------------------------------------------------------
package bihc_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned INDEX_W   = 7;
	localparam int unsigned PADDR_W   = 4;

	localparam int unsigned CRC_WORDS_DEF        = 16;
	localparam int unsigned MAGIC_WORD_INDEX_DEF = 64;

	localparam logic [WORD_W-1:0] CRC_POLY      = 32'hEDB8_8320;
	localparam logic [WORD_W-1:0] CRC_INIT      = 32'hFFFF_FFFF;
	localparam logic [WORD_W-1:0] STACK_LOW_RST  = 32'h2000_0000;
	localparam logic [WORD_W-1:0] STACK_HIGH_RST = 32'h2004_0000;
	localparam logic [WORD_W-1:0] MAGIC_RST      = 32'hDEAD_BEEF;

	// Register indexes (byte address = 4 * index)
	typedef enum logic [1:0] {
		REG_STACK_LOW  = 2'd0,
		REG_STACK_HIGH = 2'd1,
		REG_MAGIC      = 2'd2
	} reg_idx_t;

	// First failed application check
	typedef enum logic [1:0] {
		FF_NONE  = 2'd0,
		FF_MAGIC = 2'd1,
		FF_STACK = 2'd2,
		FF_CRC   = 2'd3
	} fail_t;

	// Boot decision
	typedef enum logic [1:0] {
		DEC_APP    = 2'd0,
		DEC_GOLDEN = 2'd1,
		DEC_NONE   = 2'd2
	} decision_t;

	typedef struct packed {
		logic [WORD_W-1:0] stack_low;
		logic [WORD_W-1:0] stack_high;
		logic [WORD_W-1:0] magic_value;
	} cfg_t;

	typedef struct packed {
		logic      app_magic_ok;
		logic      app_stack_ok;
		logic      app_crc_ok;
		logic      golden_magic_ok;
		logic      golden_stack_ok;
		fail_t     first_failure;
		decision_t decision;
	} verdict_t;

	// One byte of the reflected CRC-32: eight shift/xor steps.
	function automatic logic [WORD_W-1:0] crc_fold_byte(
		input logic [WORD_W-1:0] crc,
		input logic [7:0]        data
	);
		logic [WORD_W-1:0] c;
		c = crc ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
		end
		return c;
	endfunction

	// Whole word, little-endian byte order.
	function automatic logic [WORD_W-1:0] crc_fold_word(
		input logic [WORD_W-1:0] crc,
		input logic [WORD_W-1:0] word
	);
		logic [WORD_W-1:0] c;
		c = crc;
		for (int b = 0; b < 4; b++) begin
			c = crc_fold_byte(c, word[8*b +: 8]);
		end
		return c;
	endfunction

endpackage

FILE: sv/bihc_regs.sv
// ----------------------------------------------------------------------------
// bihc_regs: configuration registers
// APB-style write/read access to the stack window and magic value.
// ----------------------------------------------------------------------------
module bihc_regs
	import bihc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [WORD_W-1:0]  pwdata,
	output logic [WORD_W-1:0]  prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t sel_idx;
	logic     wr_en;

	assign pready  = 1'b1;
	assign sel_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stack_low   <= STACK_LOW_RST;
			cfg_q.stack_high  <= STACK_HIGH_RST;
			cfg_q.magic_value <= MAGIC_RST;
		end else if (wr_en) begin
			case (sel_idx)
				REG_STACK_LOW:  cfg_q.stack_low   <= pwdata;
				REG_STACK_HIGH: cfg_q.stack_high  <= pwdata;
				REG_MAGIC:      cfg_q.magic_value <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel_idx)
			REG_STACK_LOW:  prdata = cfg_q.stack_low;
			REG_STACK_HIGH: prdata = cfg_q.stack_high;
			REG_MAGIC:      prdata = cfg_q.magic_value;
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/bihc_check.sv
// ----------------------------------------------------------------------------
// bihc_check: header check state and evaluation
// Holds the running CRC and the per-image flags, evaluates one header word
// per cycle while update is high and forms the verdict from the updated flags.
// ----------------------------------------------------------------------------
module bihc_check
	import bihc_pkg::*;
#(
	parameter int unsigned CRC_WORDS        = CRC_WORDS_DEF,
	parameter int unsigned MAGIC_WORD_INDEX = MAGIC_WORD_INDEX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               update,
	input  logic               image_sel,
	input  logic [INDEX_W-1:0] word_index,
	input  logic [WORD_W-1:0]  word_data,
	input  cfg_t               cfg,
	output verdict_t           verdict
);

	localparam logic [INDEX_W-1:0] CRC_IDX   = INDEX_W'(CRC_WORDS);
	localparam logic [INDEX_W-1:0] MAGIC_IDX = INDEX_W'(MAGIC_WORD_INDEX);

	logic [WORD_W-1:0] crc_acc_q, crc_base, crc_nxt;
	logic [2:0]        app_flags_q, app_nxt;     // bit0 magic, bit1 stack, bit2 crc
	logic [1:0]        gold_flags_q, gold_nxt;   // bit0 magic, bit1 stack
	logic              sp_ok, magic_hit, is_zero;

	assign sp_ok     = (word_data >= cfg.stack_low) && (word_data < cfg.stack_high)
	                   && (word_data[2:0] == 3'd0);
	assign magic_hit = (word_data == cfg.magic_value);
	assign is_zero   = (word_index == '0);

	always_comb begin
		crc_nxt  = crc_acc_q;
		app_nxt  = app_flags_q;
		gold_nxt = gold_flags_q;
		crc_base = is_zero ? CRC_INIT : crc_acc_q;
		if (!image_sel) begin
			if (is_zero) begin
				app_nxt = {1'b0, sp_ok, 1'b0};
				crc_nxt = CRC_INIT;
			end
			if (word_index < CRC_IDX) begin
				crc_nxt = crc_fold_word(crc_base, word_data);
			end
			if (word_index == CRC_IDX) begin
				app_nxt[2] = ((crc_acc_q ^ CRC_INIT) == word_data);
			end
			if (word_index == MAGIC_IDX) begin
				app_nxt[0] = magic_hit;
			end
		end else begin
			if (is_zero) begin
				gold_nxt = {sp_ok, 1'b0};
			end
			if (word_index == MAGIC_IDX) begin
				gold_nxt[0] = magic_hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_acc_q    <= CRC_INIT;
			app_flags_q  <= '0;
			gold_flags_q <= '0;
		end else if (update) begin
			crc_acc_q    <= crc_nxt;
			app_flags_q  <= app_nxt;
			gold_flags_q <= gold_nxt;
		end
	end

	always_comb begin
		verdict.app_magic_ok    = app_nxt[0];
		verdict.app_stack_ok    = app_nxt[1];
		verdict.app_crc_ok      = app_nxt[2];
		verdict.golden_magic_ok = gold_nxt[0];
		verdict.golden_stack_ok = gold_nxt[1];
		if (!app_nxt[0])      verdict.first_failure = FF_MAGIC;
		else if (!app_nxt[1]) verdict.first_failure = FF_STACK;
		else if (!app_nxt[2]) verdict.first_failure = FF_CRC;
		else                  verdict.first_failure = FF_NONE;
		if (app_nxt == 3'b111)     verdict.decision = DEC_APP;
		else if (gold_nxt == 2'b11) verdict.decision = DEC_GOLDEN;
		else                        verdict.decision = DEC_NONE;
	end

endmodule

FILE: sv/boot_image_header_checker_core.sv
// ----------------------------------------------------------------------------
// boot_image_header_checker_core: boot image header checker
// Validates the headers of the application and golden images and reports
// the check flags and the boot decision.
// ----------------------------------------------------------------------------
// Header words of the application image (image_sel 0) and then the golden
// image (image_sel 1) stream in, one word per cycle, each image in
// ascending word order from word 0. Word 0 of an image clears its flags and
// checks the initial stack pointer against [stack_low, stack_high) with
// 8-byte alignment; for the application it also restarts the reflected
// CRC-32 that folds in words 0 to CRC_WORDS-1 and is compared with word
// CRC_WORDS. Word MAGIC_WORD_INDEX is compared with magic_value for both
// images. A word with final_req set yields one result word with the flags,
// the first failed application check and the boot decision; other words
// yield nothing. The block takes one word per cycle unless the input is
// stalled: a word sits in the input register while the CRC fold (four byte
// steps) and the compares run, then updates the check state and, when
// final, loads the output register, so a verdict reaches the outputs from
// the output register once its word retires from the input register.
// Only a held result with out_stall high stalls the input, and only when
// the word waiting in the input register is final.
// Configuration is written through the APB-style port at byte addresses
// 0 (stack_low), 4 (stack_high) and 8 (magic_value).
// ----------------------------------------------------------------------------
module boot_image_header_checker_core
	import bihc_pkg::*;
#(
	parameter int unsigned CRC_WORDS        = CRC_WORDS_DEF,
	parameter int unsigned MAGIC_WORD_INDEX = MAGIC_WORD_INDEX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [WORD_W-1:0]  pwdata,
	output logic [WORD_W-1:0]  prdata,
	output logic               pready,
	// input words
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               image_sel,
	input  logic [INDEX_W-1:0] word_index,
	input  logic [WORD_W-1:0]  word_data,
	input  logic               final_req,
	// result words
	output logic               out_valid,
	input  logic               out_stall,
	output logic               app_magic_ok,
	output logic               app_stack_ok,
	output logic               app_crc_ok,
	output logic               golden_magic_ok,
	output logic               golden_stack_ok,
	output logic [1:0]         first_failure,
	output logic [1:0]         decision
);

	cfg_t     cfg;
	verdict_t verdict, verdict_q;

	logic               valid_s1;
	logic               image_sel_s1;
	logic [INDEX_W-1:0] word_index_s1;
	logic [WORD_W-1:0]  word_data_s1;
	logic               final_req_s1;
	logic               out_valid_q;
	logic               advance;
	logic               in_take;

	bihc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Retire the staged word when it has no result, or the output slot is
	// free or being drained this cycle.
	assign advance  = valid_s1 && (!final_req_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Input register: hold the word until it retires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			image_sel_s1  <= image_sel;
			word_index_s1 <= word_index;
			word_data_s1  <= word_data;
			final_req_s1  <= final_req;
		end
	end

	bihc_check #(
		.CRC_WORDS        (CRC_WORDS),
		.MAGIC_WORD_INDEX (MAGIC_WORD_INDEX)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.update     (advance),
		.image_sel  (image_sel_s1),
		.word_index (word_index_s1),
		.word_data  (word_data_s1),
		.cfg        (cfg),
		.verdict    (verdict)
	);

	// Output register: load on a retiring final word, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && final_req_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && final_req_s1) begin
			verdict_q <= verdict;
		end
	end

	assign out_valid       = out_valid_q;
	assign app_magic_ok    = verdict_q.app_magic_ok;
	assign app_stack_ok    = verdict_q.app_stack_ok;
	assign app_crc_ok      = verdict_q.app_crc_ok;
	assign golden_magic_ok = verdict_q.golden_magic_ok;
	assign golden_stack_ok = verdict_q.golden_stack_ok;
	assign first_failure   = verdict_q.first_failure;
	assign decision        = verdict_q.decision;

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: boot image header checker testbench
// Streams application and golden header words into the checker, predicts each
// verdict from a bit-level model of the checks kept inside the bench, and
// compares every verdict field by field while both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;
	import bihc_pkg::*;

	// Cycles with no handshake before the run is declared hung
	localparam int IDLE_LIMIT   = 1000;
	// A word passes the input and output registers; drain waits a margin past that
	localparam int DRAIN_CYCLES = 6;
	localparam int PHASE_WORDS  = 300;

	// One input word as the bench sees it
	typedef struct {
		logic               sel;
		logic [INDEX_W-1:0] idx;
		logic [WORD_W-1:0]  data;
		logic               fin;
	} hdr_word_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [WORD_W-1:0]  pwdata;
	logic [WORD_W-1:0]  prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic               image_sel;
	logic [INDEX_W-1:0] word_index;
	logic [WORD_W-1:0]  word_data;
	logic               final_req;
	logic               out_valid;
	logic               out_stall;
	logic               app_magic_ok;
	logic               app_stack_ok;
	logic               app_crc_ok;
	logic               golden_magic_ok;
	logic               golden_stack_ok;
	logic [1:0]         first_failure;
	logic [1:0]         decision;

	boot_image_header_checker_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.image_sel       (image_sel),
		.word_index      (word_index),
		.word_data       (word_data),
		.final_req       (final_req),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.app_magic_ok    (app_magic_ok),
		.app_stack_ok    (app_stack_ok),
		.app_crc_ok      (app_crc_ok),
		.golden_magic_ok (golden_magic_ok),
		.golden_stack_ok (golden_stack_ok),
		.first_failure   (first_failure),
		.decision        (decision)
	);

	// Reflected CRC-32 over one word, low byte first: shifting the whole word
	// bit by bit from the LSB is the same as four byte steps in LE order.
	function automatic logic [WORD_W-1:0] crc32_fold(
		input logic [WORD_W-1:0] crc,
		input logic [WORD_W-1:0] w
	);
		logic [WORD_W-1:0] c;
		c = crc ^ w;
		for (int k = 0; k < 32; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// Verdict predictor and the store of verdicts still owed by the block
	// ------------------------------------------------------------------------
	class verdict_board;
		logic [WORD_W-1:0] stack_low;
		logic [WORD_W-1:0] stack_high;
		logic [WORD_W-1:0] magic_value;
		logic [WORD_W-1:0] crc_acc;
		logic              app_magic, app_stack, app_crc;
		logic              gold_magic, gold_stack;
		verdict_t          owed_verdicts[$];
		int                mismatches;
		int                verdicts_checked;

		function new();
			stack_low        = STACK_LOW_RST;
			stack_high       = STACK_HIGH_RST;
			magic_value      = MAGIC_RST;
			crc_acc          = CRC_INIT;
			app_magic        = 1'b0;
			app_stack        = 1'b0;
			app_crc          = 1'b0;
			gold_magic       = 1'b0;
			gold_stack       = 1'b0;
			mismatches       = 0;
			verdicts_checked = 0;
		endfunction

		function void set_reg(reg_idx_t r, logic [WORD_W-1:0] v);
			case (r)
				REG_STACK_LOW:  stack_low   = v;
				REG_STACK_HIGH: stack_high  = v;
				REG_MAGIC:      magic_value = v;
				default: ;
			endcase
		endfunction

		function bit sp_valid(logic [WORD_W-1:0] sp);
			return (sp >= stack_low) && (sp < stack_high) && (sp[2:0] == 3'd0);
		endfunction

		// Apply one accepted word; queue a verdict when the word is final
		function void note_word(hdr_word_t w);
			verdict_t v;
			if (!w.sel) begin
				if (w.idx == 0) begin
					app_magic = 1'b0;
					app_crc   = 1'b0;
					crc_acc   = CRC_INIT;
					app_stack = sp_valid(w.data);
				end
				if (w.idx < CRC_WORDS_DEF)
					crc_acc = crc32_fold(crc_acc, w.data);
				if (w.idx == CRC_WORDS_DEF)
					app_crc = ((crc_acc ^ CRC_INIT) == w.data);
				if (w.idx == MAGIC_WORD_INDEX_DEF)
					app_magic = (w.data == magic_value);
			end else begin
				if (w.idx == 0) begin
					gold_magic = 1'b0;
					gold_stack = sp_valid(w.data);
				end
				if (w.idx == MAGIC_WORD_INDEX_DEF)
					gold_magic = (w.data == magic_value);
			end
			if (!w.fin)
				return;
			v.app_magic_ok    = app_magic;
			v.app_stack_ok    = app_stack;
			v.app_crc_ok      = app_crc;
			v.golden_magic_ok = gold_magic;
			v.golden_stack_ok = gold_stack;
			if (!app_magic)
				v.first_failure = FF_MAGIC;
			else if (!app_stack)
				v.first_failure = FF_STACK;
			else if (!app_crc)
				v.first_failure = FF_CRC;
			else
				v.first_failure = FF_NONE;
			if (v.first_failure == FF_NONE)
				v.decision = DEC_APP;
			else if (gold_magic && gold_stack)
				v.decision = DEC_GOLDEN;
			else
				v.decision = DEC_NONE;
			owed_verdicts.push_back(v);
		endfunction

		function void compare_field(string field, logic [1:0] want, logic [1:0] got);
			if (want !== got) begin
				mismatches++;
				$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			end
		endfunction

		function void check_verdict(verdict_t got);
			verdict_t want;
			if (owed_verdicts.size() == 0) begin
				mismatches++;
				$display("%0t: verdict with none expected, expected nothing, got %h",
					$time, got);
				return;
			end
			want = owed_verdicts.pop_front();
			verdicts_checked++;
			compare_field("app_magic_ok",    want.app_magic_ok,    got.app_magic_ok);
			compare_field("app_stack_ok",    want.app_stack_ok,    got.app_stack_ok);
			compare_field("app_crc_ok",      want.app_crc_ok,      got.app_crc_ok);
			compare_field("golden_magic_ok", want.golden_magic_ok, got.golden_magic_ok);
			compare_field("golden_stack_ok", want.golden_stack_ok, got.golden_stack_ok);
			compare_field("first_failure",   want.first_failure,   got.first_failure);
			compare_field("decision",        want.decision,        got.decision);
		endfunction

		function int pending();
			return owed_verdicts.size();
		endfunction
	endclass

	verdict_board sb;
	hdr_word_t    scan_q[$];
	int           words_sent;
	int           stall_left;
	int           phases_run;
	bit           calm;		// no idling on either side while set
	cfg_t         phase_cfg[5];

	// ------------------------------------------------------------------------
	// Clock, result monitor, output stall and watchdog
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check each verdict word at the edge that moves it, then draw the stall
	// that the next verdict will see.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_verdict(verdict_t'({app_magic_ok, app_stack_ok, app_crc_ok,
				golden_magic_ok, golden_stack_ok, first_failure, decision}));
			stall_left = calm ? 0 : $urandom_range(0, 15);
		end
	end

	// Hold stall for the drawn number of cycles, changing only at falling edges
	initial begin
		out_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Any handshake or configuration access restarts the count
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: watchdog, no handshake for %0d cycles, %0d verdicts owed",
			$time, IDLE_LIMIT, sb.pending());
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Present one word after a random gap and hold it until accepted.
	// Valid stays high into the next call, so a zero gap means back to back.
	task automatic send_word(hdr_word_t w);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 15);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		image_sel  <= w.sel;
		word_index <= w.idx;
		word_data  <= w.data;
		final_req  <= w.fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_word(w);
		words_sent++;
	endtask

	task automatic send_fields(logic sel, int idx, logic [WORD_W-1:0] data, logic fin);
		hdr_word_t w;
		w.sel  = sel;
		w.idx  = idx[INDEX_W-1:0];
		w.data = data;
		w.fin  = fin;
		send_word(w);
	endtask

	// Drop valid, wait out every owed verdict, then let the pipe empty
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register, then read it back over the same port
	task automatic cfg_write(reg_idx_t r, logic [WORD_W-1:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_reg(r, v);
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== v) begin
			sb.mismatches++;
			$display("%0t: readback of %s expected %h, got %h", $time, r.name(), v, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	// Stack pointer: mostly in range and aligned, else near or past the bounds
	function automatic logic [WORD_W-1:0] pick_sp();
		logic [63:0]       span;
		logic [WORD_W-1:0] sp;
		span = {32'd0, sb.stack_high} - {32'd0, sb.stack_low};
		case ($urandom_range(0, 9))
			0: sp = sb.stack_low + $urandom_range(1, 7);
			1: sp = sb.stack_low - 32'd8;
			2: sp = sb.stack_high;
			3: sp = sb.stack_high - 32'd8;
			4: sp = $urandom;
			default: begin
				if (sb.stack_high > sb.stack_low)
					sp = (sb.stack_low + 32'({$urandom} % span)) & ~32'h7;
				else
					sp = $urandom;
			end
		endcase
		return sp;
	endfunction

	function automatic logic [WORD_W-1:0] pick_magic();
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return sb.magic_value ^ (32'd1 << $urandom_range(0, 31));
			default: return sb.magic_value;
		endcase
	endfunction

	function automatic void add_word(logic sel, int idx, logic [WORD_W-1:0] data);
		hdr_word_t w;
		w.sel  = sel;
		w.idx  = idx[INDEX_W-1:0];
		w.data = data;
		w.fin  = 1'b0;
		scan_q.push_back(w);
	endfunction

	// One scan of both headers: the app vector table with its CRC word and
	// magic, then the golden stack and magic. A broken scan drops, repeats,
	// swaps or finalizes a word early.
	task automatic build_scan(bit broken);
		logic [WORD_W-1:0] crc;
		logic [WORD_W-1:0] d;
		hdr_word_t         tmp;
		int                i;
		int                j;
		scan_q.delete();
		crc = CRC_INIT;
		for (i = 0; i < CRC_WORDS_DEF; i++) begin
			d = (i == 0) ? pick_sp() : $urandom;
			crc = crc32_fold(crc, d);
			add_word(1'b0, i, d);
		end
		d = crc ^ CRC_INIT;
		if ($urandom_range(0, 7) == 0)
			d = d ^ (32'd1 << $urandom_range(0, 31));
		add_word(1'b0, CRC_WORDS_DEF, d);
		repeat ($urandom_range(0, 2))
			add_word(1'b0, $urandom_range(CRC_WORDS_DEF + 1, MAGIC_WORD_INDEX_DEF - 1), $urandom);
		add_word(1'b0, MAGIC_WORD_INDEX_DEF, pick_magic());
		add_word(1'b1, 0, pick_sp());
		// golden words up to the CRC word must leave the app CRC alone
		repeat ($urandom_range(0, 2))
			add_word(1'b1, $urandom_range(1, CRC_WORDS_DEF), $urandom);
		add_word(1'b1, MAGIC_WORD_INDEX_DEF, pick_magic());
		if ($urandom_range(0, 3) == 0)
			add_word(1'b1, $urandom_range(MAGIC_WORD_INDEX_DEF + 1, 127), $urandom);
		if (broken) begin
			i = $urandom_range(0, scan_q.size() - 1);
			j = $urandom_range(0, scan_q.size() - 1);
			case ($urandom_range(0, 3))
				0: scan_q.delete(i);
				1: scan_q.insert(j, scan_q[i]);
				2: scan_q[i].fin = 1'b1;
				default: begin
					tmp       = scan_q[i];
					scan_q[i] = scan_q[j];
					scan_q[j] = tmp;
				end
			endcase
		end
		scan_q[scan_q.size() - 1].fin = 1'b1;
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6))
			send_fields($urandom_range(0, 1), $urandom_range(0, 127), $urandom,
				$urandom_range(0, 3) == 0);
	endtask

	task automatic run_phase(int n_words);
		int target;
		int kind;
		target = words_sent + n_words;
		while (words_sent < target) begin
			calm = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				send_noise();
			end else begin
				build_scan(kind == 1);
				foreach (scan_q[k])
					send_word(scan_q[k]);
			end
		end
		calm = 1'b0;
		drain();
		phases_run++;
	endtask

	// Hand-picked words under the reset configuration
	task automatic run_directed();
		logic [WORD_W-1:0] sp_crc;
		sp_crc = crc32_fold(CRC_INIT, STACK_LOW_RST) ^ CRC_INIT;
		// verdict before any header word: every check missing
		send_fields(1'b0, 127, 32'h0000_0000, 1'b1);
		// app stack at the lower bound, CRC over word 0 alone
		send_fields(1'b0, 0, STACK_LOW_RST, 1'b0);
		send_fields(1'b1, 5, 32'hFFFF_FFFF, 1'b0);
		send_fields(1'b0, CRC_WORDS_DEF, sp_crc, 1'b0);
		send_fields(1'b0, MAGIC_WORD_INDEX_DEF, MAGIC_RST, 1'b1);
		// vector word arrives again after the CRC word: CRC now fails
		send_fields(1'b0, 3, 32'h1234_5678, 1'b0);
		send_fields(1'b0, CRC_WORDS_DEF, sp_crc, 1'b1);
		// golden stack just under the upper bound
		send_fields(1'b1, 0, STACK_HIGH_RST - 32'd8, 1'b0);
		send_fields(1'b1, MAGIC_WORD_INDEX_DEF, MAGIC_RST, 1'b1);
		// app stack at the exclusive bound, then misaligned, then below range
		send_fields(1'b0, 0, STACK_HIGH_RST, 1'b0);
		send_fields(1'b0, MAGIC_WORD_INDEX_DEF, MAGIC_RST, 1'b1);
		send_fields(1'b0, 0, STACK_LOW_RST + 32'd4, 1'b0);
		send_fields(1'b0, MAGIC_WORD_INDEX_DEF, MAGIC_RST, 1'b1);
		// final on word zero: flags clear first
		send_fields(1'b0, 0, STACK_LOW_RST - 32'd8, 1'b1);
		send_fields(1'b1, MAGIC_WORD_INDEX_DEF, 32'h0000_0000, 1'b1);
		send_fields(1'b1, 0, 32'hFFFF_FFFF, 1'b1);
		send_fields(1'b0, 127, 32'hFFFF_FFFF, 1'b0);
		send_fields(1'b1, 127, 32'h0000_0000, 1'b1);
		drain();
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		in_valid   = 1'b0;
		image_sel  = 1'b0;
		word_index = '0;
		word_data  = '0;
		final_req  = 1'b0;
		calm       = 1'b0;
		words_sent = 0;
		phases_run = 0;
		sb         = new();
		arst_n     = 1'b0;

		// full range, narrow range at the top, inverted range, random, then
		// back to the reset values
		phase_cfg[0] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
		phase_cfg[1] = '{32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
		phase_cfg[2] = '{32'h0802_0000, 32'h0800_0000, 32'h0000_0000};
		phase_cfg[3] = '{32'h0, 32'h0, 32'h0};
		phase_cfg[4] = '{STACK_LOW_RST, STACK_HIGH_RST, MAGIC_RST};
		phase_cfg[2].magic_value = $urandom;
		phase_cfg[3].stack_low   = $urandom_range(0, 32'h7FFF_FFFF);
		phase_cfg[3].stack_high  = phase_cfg[3].stack_low + $urandom_range(8, 32'h0100_0000);
		phase_cfg[3].magic_value = $urandom;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values first, with the directed words, then each setting
		run_directed();
		run_phase(PHASE_WORDS);
		foreach (phase_cfg[p]) begin
			cfg_write(REG_STACK_LOW,  phase_cfg[p].stack_low);
			cfg_write(REG_STACK_HIGH, phase_cfg[p].stack_high);
			cfg_write(REG_MAGIC,      phase_cfg[p].magic_value);
			run_phase(PHASE_WORDS);
		end

		$display("Sent %0d header words over %0d register settings; %0d verdicts compared.",
			words_sent, phases_run, sb.verdicts_checked);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
